// ===== rtl/core/rrsd_pkg.sv =====
`timescale 1ns / 1ps
// rrsd_pkg: shared types, constants and the square root step of the safety distance unit
// no dependencies; used by the interfaces and every module of the block

package rrsd_pkg;

	localparam int LEN_W = 31;
	localparam logic [LEN_W-1:0] DIST_MAX = '1;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLE_X_LOW,
		REG_HOLE_X_HIGH,
		REG_HOLE_Y_LOW,
		REG_HOLE_Y_HIGH,
		REG_JAW_WIDTH,
		REG_SLAB_HEIGHT
	} cfg_reg_t;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// corner root datapath
	localparam int SQ_W       = 2 * LEN_W;
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int SQRT_STEPS = ROOT_W;

	typedef struct packed {
		logic [LEN_W-1:0] lin;
		logic             corner;
		logic [LEN_W-1:0] dx;
		logic [LEN_W-1:0] dy;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t work;
	} push_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_status_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	// one restoring digit of floor(sqrt): pulls in two radicand bits, yields one root bit
	function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [1:0] bits);
		logic [REM_W+1:0] pulled;
		logic [REM_W+1:0] test;
		logic [REM_W+1:0] diff;
		sqrt_t            nxt;
		pulled = {cur.rem, bits};
		test   = {2'b00, cur.root, 2'b01};
		diff   = pulled - test;
		if (pulled >= test) begin
			nxt.rem  = diff[REM_W-1:0];
			nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = pulled[REM_W-1:0];
			nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// ===== rtl/core/rrsd_if.sv =====
`timescale 1ns / 1ps
// rrsd_if: valid/ready channel interfaces for points, results and register writes
// depends on rrsd_pkg

interface rrsd_point_if #(parameter int COORD_WIDTH = 32);
	import rrsd_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;

	modport source(output valid, output point_x, output point_y, output point_z, input ready);
	modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface rrsd_dist_if;
	import rrsd_pkg::*;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] safe_distance;

	modport source(output valid, output safe_distance, input ready);
	modport sink(input valid, input safe_distance, output ready);
endinterface

interface rrsd_cfg_if #(parameter int DATA_W = 32);
	import rrsd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rrsd_front.sv =====
`timescale 1ns / 1ps
// rrsd_front: geometry registers, point intake and three-stage classification pipeline
// depends on rrsd_pkg and rrsd_if; feeds rrsd_queue

module rrsd_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rrsd_cfg_if.sink              cfg,
	rrsd_point_if.sink            point,
	output rrsd_pkg::push_t       push,
	input  rrsd_pkg::q_status_t   q_status
);
	import rrsd_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int BW = (CW > LEN_W) ? CW : LEN_W;
	localparam int DW = BW + 3;
	localparam logic signed [DW-1:0] MAX_E = signed'(DW'(DIST_MAX));

	function automatic logic signed [DW-1:0] smin(
		input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b
	);
		return (a < b) ? a : b;
	endfunction

	// geometry registers
	logic signed [CW-1:0] hole_xl_q, hole_xh_q, hole_yl_q, hole_yh_q;
	logic [LEN_W-1:0]     jaw_q, height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_xl_q <= '0;
			hole_xh_q <= '0;
			hole_yl_q <= '0;
			hole_yh_q <= '0;
			jaw_q     <= '0;
			height_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_HOLE_X_LOW:  hole_xl_q <= cfg.data[CW-1:0];
				REG_HOLE_X_HIGH: hole_xh_q <= cfg.data[CW-1:0];
				REG_HOLE_Y_LOW:  hole_yl_q <= cfg.data[CW-1:0];
				REG_HOLE_Y_HIGH: hole_yh_q <= cfg.data[CW-1:0];
				REG_JAW_WIDTH:   jaw_q     <= cfg.data[LEN_W-1:0];
				REG_SLAB_HEIGHT: height_q  <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables, each stage moves when the next one has room
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3 = !v_s3 || !q_status.full;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign point.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= point.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: all offsets
	logic signed [DW-1:0] x_e, y_e, z_e, lx_e, hx_e, ly_e, hy_e, jaw_e, h_e;

	assign x_e   = DW'(point.point_x);
	assign y_e   = DW'(point.point_y);
	assign z_e   = DW'(point.point_z);
	assign lx_e  = DW'(hole_xl_q);
	assign hx_e  = DW'(hole_xh_q);
	assign ly_e  = DW'(hole_yl_q);
	assign hy_e  = DW'(hole_yh_q);
	assign jaw_e = DW'(jaw_q);
	assign h_e   = DW'(height_q);

	logic signed [DW-1:0] dxl_s1, dxh_s1, dyl_s1, dyh_s1, z_s1, zh_s1;
	logic signed [DW-1:0] ox1_s1, ox2_s1, oy1_s1, oy2_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			dxl_s1 <= lx_e - x_e;
			dxh_s1 <= x_e - hx_e;
			dyl_s1 <= ly_e - y_e;
			dyh_s1 <= y_e - hy_e;
			z_s1   <= z_e;
			zh_s1  <= h_e - z_e;
			ox1_s1 <= x_e - lx_e + jaw_e;
			ox2_s1 <= hx_e + jaw_e - x_e;
			oy1_s1 <= y_e - ly_e + jaw_e;
			oy2_s1 <= hy_e + jaw_e - y_e;
		end
	end

	// stage 2: hole side classification and partial minima
	logic                 xl, xh, yl, yh;
	logic signed [DW-1:0] hole_lin;

	assign xl = !dxl_s1[DW-1];
	assign xh = !dxh_s1[DW-1];
	assign yl = dyl_s1 > 0;
	assign yh = dyh_s1 > 0;

	always_comb begin
		if (xl)      hole_lin = dxl_s1;
		else if (xh) hole_lin = dxh_s1;
		else if (yl) hole_lin = dyl_s1;
		else if (yh) hole_lin = dyh_s1;
		else         hole_lin = '0;
	end

	logic signed [DW-1:0] mz_s2, mox_s2, moy_s2, hole_s2, dx_s2, dy_s2;
	logic                 corner_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			mz_s2     <= smin(z_s1, zh_s1);
			mox_s2    <= smin(ox1_s1, ox2_s1);
			moy_s2    <= smin(oy1_s1, oy2_s1);
			hole_s2   <= hole_lin;
			corner_s2 <= (xl || xh) && (yl || yh);
			dx_s2     <= xl ? dxl_s1 : dxh_s1;
			dy_s2     <= yl ? dyl_s1 : dyh_s1;
		end
	end

	// stage 3: straight-line minimum, clamped and saturated
	logic signed [DW-1:0] hole_or, m_all;
	work_t                work_d, work_s3;

	always_comb begin
		hole_or        = corner_s2 ? MAX_E : hole_s2;
		m_all          = smin(smin(mz_s2, mox_s2), smin(moy_s2, hole_or));
		work_d.lin     = m_all[DW-1] ? '0 : ((m_all > MAX_E) ? DIST_MAX : m_all[LEN_W-1:0]);
		// a corner offset at or above the maximum cannot lower the result
		work_d.corner  = corner_s2 && (dx_s2 < MAX_E) && (dy_s2 < MAX_E);
		work_d.dx      = dx_s2[LEN_W-1:0];
		work_d.dy      = dy_s2[LEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en3) work_s3 <= work_d;
	end

	assign push.valid = v_s3;
	assign push.work  = work_s3;

endmodule

// ===== rtl/core/rrsd_queue.sv =====
`timescale 1ns / 1ps
// rrsd_queue: small fifo of classified items between front and back
// depends on rrsd_pkg

module rrsd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrsd_pkg::push_t      push,
	input  logic                 pop,
	output rrsd_pkg::work_t      head,
	output rrsd_pkg::q_status_t  status
);
	import rrsd_pkg::*;

	work_t             store_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign status.full  = cnt_q == QCNT_W'(QDEPTH);
	assign status.empty = cnt_q == '0;
	assign status.count = cnt_q;

	assign do_push = push.valid && !status.full;
	assign do_pop  = pop && !status.empty;
	assign head    = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) store_q[wr_ptr_q] <= push.work;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/rrsd_back.sv =====
`timescale 1ns / 1ps
// rrsd_back: corner distance datapath, squares, pipelined square root and final minimum
// depends on rrsd_pkg and rrsd_if; drains rrsd_queue

module rrsd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrsd_pkg::work_t      head,
	input  rrsd_pkg::q_status_t  q_status,
	output logic                 pop,
	rrsd_dist_if.source          distance
);
	import rrsd_pkg::*;

	localparam int LAST = SQRT_STEPS - 1;

	logic adv;
	logic out_v_q;
	logic [LEN_W-1:0] dist_q;

	// whole back pipeline holds while the output transaction is pending
	assign adv = !out_v_q || distance.ready;
	assign pop = adv && !q_status.empty;

	// stage 1: squares
	logic              v_s1, cor_s1;
	logic [LEN_W-1:0]  lin_s1;
	logic [SQ_W-1:0]   sqx_s1, sqy_s1;

	// stage 2: radicand
	logic              v_s2, cor_s2;
	logic [LEN_W-1:0]  lin_s2;
	logic [RAD_W-1:0]  rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_status.empty;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1 <= SQ_W'(head.dx) * SQ_W'(head.dx);
			sqy_s1 <= SQ_W'(head.dy) * SQ_W'(head.dy);
			lin_s1 <= head.lin;
			cor_s1 <= head.corner;
			rad_s2 <= RAD_W'(sqx_s1) + RAD_W'(sqy_s1);
			lin_s2 <= lin_s1;
			cor_s2 <= cor_s1;
		end
	end

	// root stages, one bit each
	logic             vld_q  [SQRT_STEPS];
	logic             cor_q  [SQRT_STEPS];
	logic [LEN_W-1:0] lin_q  [SQRT_STEPS];
	sqrt_t            sq_q   [SQRT_STEPS];
	logic [RAD_W-1:0] rad_q  [SQRT_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_q[0]  <= sqrt_step('0, rad_s2[RAD_W-1 -: 2]);
			rad_q[0] <= rad_s2 << 2;
			lin_q[0] <= lin_s2;
			cor_q[0] <= cor_s2;
		end
	end

	for (genvar k = 1; k < SQRT_STEPS; k++) begin : g_root
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv) begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_q[k]  <= sqrt_step(sq_q[k-1], rad_q[k-1][RAD_W-1 -: 2]);
				lin_q[k] <= lin_q[k-1];
				cor_q[k] <= cor_q[k-1];
			end
		end

		if (k < SQRT_STEPS - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (adv) rad_q[k] <= rad_q[k-1] << 2;
			end
		end
	end

	// final minimum against the straight-line terms
	logic [LEN_W-1:0] root_sat, result;

	always_comb begin
		root_sat = (sq_q[LAST].root > ROOT_W'(DIST_MAX)) ? DIST_MAX
			: sq_q[LAST].root[LEN_W-1:0];
		result   = (cor_q[LAST] && (root_sat < lin_q[LAST])) ? root_sat : lin_q[LAST];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= vld_q[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) dist_q <= result;
	end

	assign distance.valid         = out_v_q;
	assign distance.safe_distance = dist_q;

endmodule

// ===== rtl/core/rect_ring_safety_distance_unit.sv =====
`timescale 1ns / 1ps
// rect_ring_safety_distance_unit: top level, front classifier, queue and root back end
// depends on rrsd_pkg, rrsd_if, rrsd_front, rrsd_queue, rrsd_back
//
//  channel   direction  payload
//  cfg       in         index, data (geometry register write)
//  point     in         point_x, point_y, point_z
//  distance  out        safe_distance
//
// one point per cycle sustained if distance is ready; a point passes the front stages,
// the queue, the squares and the 32-stage square root, one root bit per stage
// reset clears all geometry registers, stage valids and the queue
// a stall on distance holds the back end; the front keeps filling the 4-entry queue,
// then point.ready drops

module rect_ring_safety_distance_unit #(
	parameter int COORD_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	rrsd_cfg_if.sink      cfg,
	rrsd_point_if.sink    point,
	rrsd_dist_if.source   distance
);
	import rrsd_pkg::*;

	push_t     push;
	q_status_t q_status;
	work_t     head;
	logic      pop;

	rrsd_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.point    (point),
		.push     (push),
		.q_status (q_status)
	);

	rrsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.status (q_status)
	);

	rrsd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.distance (distance)
	);

`ifndef SYNTHESIS
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue full and empty at once");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!point.ready |-> (push.valid && q_status.full))
		else $error("point intake stalled without a full queue");

	a_queue_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> q_status.count == QCNT_W'($past(q_status.count)
			+ $past(push.valid && !q_status.full) - $past(pop)))
		else $error("queue occupancy does not track push and pop");
`endif

endmodule

// ===== tb/sv/rect_ring_safety_distance_unit_tb.sv =====
`timescale 1ns / 1ps
// rect_ring_safety_distance_unit_tb: drives points and geometry writes into the safety distance
// unit and checks every result against an in-bench integer model of the ring slab
// depends on rrsd_pkg, rrsd_if and rect_ring_safety_distance_unit

module rect_ring_safety_distance_unit_tb;
	import rrsd_pkg::*;

	localparam int  HALF_PERIOD = 10;
	localparam int  QUIET_LIMIT = 2000;
	localparam int  DRAIN_WAIT  = 64;
	localparam longint U        = 65536;
	localparam longint S32_MAX  = 64'sd2147483647;
	localparam longint S32_MIN  = -64'sd2147483648;

	// index codes the unit does not decode, writes to them must be ignored
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

	typedef enum int {GEO_TYPICAL, GEO_WIDE, GEO_INVERTED} geo_kind_t;

	class ring_dist_board;
		longint hxl, hxh, hyl, hyh, jaw, hgt;
		logic [LEN_W-1:0] dist_due[$];
		int errs;

		function new();
			hxl = 0; hxh = 0; hyl = 0; hyh = 0; jaw = 0; hgt = 0;
			errs = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
			case (cfg_reg_t'(idx))
				REG_HOLE_X_LOW: hxl = longint'($signed(d));
				REG_HOLE_X_HIGH: hxh = longint'($signed(d));
				REG_HOLE_Y_LOW: hyl = longint'($signed(d));
				REG_HOLE_Y_HIGH: hyh = longint'($signed(d));
				REG_JAW_WIDTH: jaw = longint'({33'd0, d[LEN_W-1:0]});
				REG_SLAB_HEIGHT: hgt = longint'({33'd0, d[LEN_W-1:0]});
				default: ;
			endcase
		endfunction

		function longint lesser(longint a, longint b);
			return (a < b) ? a : b;
		endfunction

		function longint root_floor(longint unsigned v);
			longint unsigned res;
			longint unsigned bitv;
			res  = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v   = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return longint'(res);
		endfunction

		function longint corner(longint dx, longint dy);
			longint unsigned sq;
			longint r;
			if (dx >= longint'(DIST_MAX) || dy >= longint'(DIST_MAX)) return longint'(DIST_MAX);
			sq = longint'(dx * dx) + longint'(dy * dy);
			r  = root_floor(sq);
			return (r > longint'(DIST_MAX)) ? longint'(DIST_MAX) : r;
		endfunction

		function longint hole_gap(longint x, longint y);
			if (x <= hxl) begin
				if (y < hyl) return corner(hxl - x, hyl - y);
				if (y > hyh) return corner(hxl - x, y - hyh);
				return (hxl - x < 0) ? 0 : hxl - x;
			end
			if (x >= hxh) begin
				if (y < hyl) return corner(x - hxh, hyl - y);
				if (y > hyh) return corner(x - hxh, y - hyh);
				return (x - hxh < 0) ? 0 : x - hxh;
			end
			if (y < hyl) return (hyl - y < 0) ? 0 : hyl - y;
			if (y > hyh) return (y - hyh < 0) ? 0 : y - hyh;
			return 0;
		endfunction

		function longint rim_gap(longint x, longint y);
			longint m;
			m = lesser(lesser(x - (hxl - jaw), (hxh + jaw) - x),
				lesser(y - (hyl - jaw), (hyh + jaw) - y));
			return (m < 0) ? 0 : m;
		endfunction

		function logic [LEN_W-1:0] safety_dist(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
			longint x, y, z, r;
			x = longint'($signed(px));
			y = longint'($signed(py));
			z = longint'($signed(pz));
			r = lesser(lesser(z, hgt - z), lesser(rim_gap(x, y), hole_gap(x, y)));
			if (r < 0) r = 0;
			if (r > longint'(DIST_MAX)) r = longint'(DIST_MAX);
			return r[LEN_W-1:0];
		endfunction

		function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
			dist_due.push_back(safety_dist(px, py, pz));
		endfunction

		function void check_dist(logic [LEN_W-1:0] act);
			logic [LEN_W-1:0] want;
			if (dist_due.size() == 0) begin
				errs++;
				$error("safe_distance: no result expected, actual %0d", act);
			end else begin
				want = dist_due.pop_front();
				if (want !== act) begin
					errs++;
					$error("safe_distance mismatch: expected %0d, actual %0d", want, act);
				end
			end
		endfunction

		function int pending();
			return dist_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rrsd_cfg_if                        cfg_if();
	rrsd_point_if #(.COORD_WIDTH(32))  pt_if();
	rrsd_dist_if                       dist_if();

	rect_ring_safety_distance_unit #(.COORD_WIDTH(32)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_if),
		.point    (pt_if),
		.distance (dist_if)
	);

	ring_dist_board sb;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// result side stall pattern
	always @(negedge clk) begin
		dist_if.ready = ($urandom_range(99) >= recv_idle_pct);
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (dist_if.valid && dist_if.ready) sb.check_dist(dist_if.safe_distance);
			if (pt_if.valid && pt_if.ready)
				sb.note_point(pt_if.point_x, pt_if.point_y, pt_if.point_z);
			if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
			if ((dist_if.valid && dist_if.ready) || (pt_if.valid && pt_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// caller sits at a falling edge; returns at the falling edge after the transaction
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = d;
		do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
		@(negedge clk);
	endtask

	task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			pt_if.valid = 1'b0;
			@(negedge clk);
		end
		pt_if.valid   = 1'b1;
		pt_if.point_x = x;
		pt_if.point_y = y;
		pt_if.point_z = z;
		do @(posedge clk); while (!(pt_if.valid && pt_if.ready));
		@(negedge clk);
	endtask

	// lets every outstanding point come back before the geometry changes
	task automatic settle();
		pt_if.valid  = 1'b0;
		cfg_if.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic load_geometry(input logic [31:0] xl, input logic [31:0] xh,
		input logic [31:0] yl, input logic [31:0] yh, input logic [31:0] jw,
		input logic [31:0] ht);
		settle();
		write_reg(REG_HOLE_X_LOW, xl);
		write_reg(REG_HOLE_X_HIGH, xh);
		write_reg(REG_HOLE_Y_LOW, yl);
		write_reg(REG_HOLE_Y_HIGH, yh);
		write_reg(REG_JAW_WIDTH, jw);
		write_reg(REG_SLAB_HEIGHT, ht);
		cfg_if.valid = 1'b0;
	endtask

	function automatic logic [31:0] clip32(longint v);
		if (v > S32_MAX) v = S32_MAX;
		if (v < S32_MIN) v = S32_MIN;
		return v[31:0];
	endfunction

	// coordinate near a ring: bounds hit exactly or by one, else anywhere in a padded span
	function automatic logic [31:0] pick_coord(longint lo, longint hi, longint b0, longint b1);
		longint a, b, pad, span;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		pad = (b - a) / 8 + 2;
		a = a - pad;
		b = b + pad;
		span = b - a;
		case ($urandom_range(9))
			0: return clip32(b0 + longint'($urandom_range(2)) - 1);
			1: return clip32(b1 + longint'($urandom_range(2)) - 1);
			2: return clip32(lo + longint'($urandom_range(2)) - 1);
			3: return clip32(hi + longint'($urandom_range(2)) - 1);
			default: begin
				if (span > 64'sd4294967295) return $urandom;
				return clip32(a + longint'($urandom_range(32'(span))));
			end
		endcase
	endfunction

	task automatic random_geometry(input geo_kind_t kind);
		longint cx, cy, wx, wy;
		cx = longint'($urandom_range(1 << 25)) - (1 << 24);
		cy = longint'($urandom_range(1 << 25)) - (1 << 24);
		wx = longint'($urandom_range(1 << 22));
		wy = longint'($urandom_range(1 << 22));
		case (kind)
			GEO_WIDE: load_geometry($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			GEO_INVERTED: load_geometry(clip32(cx + wx + 1), clip32(cx), clip32(cy + wy + 1),
				clip32(cy), $urandom_range(1 << 22), $urandom_range(1 << 22));
			default: load_geometry(clip32(cx), clip32(cx + wx), clip32(cy), clip32(cy + wy),
				($urandom_range(7) == 0) ? 32'd0 : $urandom_range(1 << 22),
				$urandom_range(1 << 22));
		endcase
	endtask

	task automatic random_points(input int n);
		logic [31:0] x, y, z;
		repeat (n) begin
			if ($urandom_range(99) < 20) begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
			end else begin
				x = pick_coord(sb.hxl - sb.jaw, sb.hxh + sb.jaw, sb.hxl, sb.hxh);
				y = pick_coord(sb.hyl - sb.jaw, sb.hyh + sb.jaw, sb.hyl, sb.hyh);
				z = pick_coord(0, sb.hgt, 0, sb.hgt);
			end
			send_point(x, y, z);
		end
	endtask

	task automatic random_phase(input int s_idle, input int r_idle);
		settle();
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		random_geometry(GEO_TYPICAL);
		random_points(42);
		random_geometry(GEO_WIDE);
		random_points(42);
		random_geometry(GEO_INVERTED);
		random_points(42);
		random_geometry(GEO_TYPICAL);
		random_points(42);
	endtask

	initial begin
		sb = new();
		send_idle_pct = 7;
		recv_idle_pct = 72;
		quiet         = 0;
		arst_n        = 1'b0;
		cfg_if.valid  = 1'b0;
		cfg_if.index  = '0;
		cfg_if.data   = '0;
		pt_if.valid   = 1'b0;
		pt_if.point_x = '0;
		pt_if.point_y = '0;
		pt_if.point_z = '0;
		dist_if.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset geometry: degenerate slab, every distance is zero
		send_point(32'(5 * U), 32'(U), 32'(2 * U));

		// hole x -8..8, y -4..4, jaw 6, height 10
		load_geometry(32'(-8 * U), 32'(8 * U), 32'(-4 * U), 32'(4 * U), 32'(6 * U),
			32'(10 * U));
		send_point(32'd0, 32'd0, 32'(5 * U));
		send_point(32'(-11 * U), 32'd0, 32'(5 * U));
		send_point(32'(10 * U), 32'(6 * U), 32'(5 * U));
		send_point(32'(-9 * U - 1234), 32'(-5 * U - 77), 32'(7 * U));
		send_point(32'd0, 32'(-7 * U), 32'd0);
		send_point(32'd0, 32'(-7 * U), 32'(10 * U));
		send_point(32'd0, 32'(-7 * U), 32'hFFFF_FFFF);
		send_point(32'd0, 32'(-7 * U), 32'(10 * U + 1));
		send_point(32'(-15 * U), 32'd0, 32'(5 * U));
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'(5 * U));
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'(-8 * U), 32'(-4 * U), 32'(3 * U));
		send_point(32'(8 * U), 32'(4 * U + 1), 32'(2 * U));

		// extreme, inverted bounds and over-wide lengths; spare indexes change nothing
		load_geometry(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_reg(IDX_SPARE_A, 32'hFFFF_FFFF);
		write_reg(IDX_SPARE_B, 32'h5A5A_A5A5);
		cfg_if.valid = 1'b0;
		send_point(32'h8000_0000, 32'h8000_0000, 32'h3FFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000);
		send_point(32'd0, 32'd0, 32'h3FFF_FFFF);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

		// full-range hole, zero jaw and height
		load_geometry(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
		send_point(32'd0, 32'd0, 32'd0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		send_point(32'd123, 32'd456, 32'hFFFF_FFFB);

		// point hole with maximal jaw and height, large corner roots
		load_geometry(32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
		send_point(32'h6000_0000, 32'h6000_0000, 32'h3FFF_FFFF);

		random_phase(7, 72);
		random_phase(72, 7);
		random_phase(0, 0);

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errs == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rrsd_pkg.sv
rtl/core/rrsd_if.sv
rtl/core/rrsd_front.sv
rtl/core/rrsd_queue.sv
rtl/core/rrsd_back.sv
rtl/core/rect_ring_safety_distance_unit.sv
tb/sv/rect_ring_safety_distance_unit_tb.sv
